// ===== src/lcdnw_pkg.sv =====
// Shared types and constants for the character LCD 4-bit write sequencer.
// No dependencies.
package lcdnw_pkg;

   localparam int unsigned EN_MASK_DEFAULT = 2;
   localparam int unsigned RS_MASK_DEFAULT = 1;

   // init: nine power-on nibble writes, then four set-up commands of four writes each
   localparam int unsigned INIT_NIBBLES = 9;
   localparam int unsigned INIT_STEPS   = 25;
   localparam int unsigned STEP_W       = $clog2(INIT_STEPS);

   localparam logic [4:0] WAIT_BYTE  = 5'd4;
   localparam logic [4:0] WAIT_CLEAR = 5'd6;

   localparam logic [7:0] CMD_FUNC_SET = 8'h2C;
   localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
   localparam logic [7:0] CMD_ENTRY    = 8'h06;
   localparam logic [7:0] CMD_HOME_POS = 8'h80;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] LINE2_BASE   = 8'h40;
   // set-position base with the one-based column correction folded in (0x80 - 1)
   localparam logic [7:0] POS_BASE     = 8'h7F;

   typedef enum logic [2:0] {
      KIND_INIT  = 3'd0,
      KIND_CMD   = 3'd1,
      KIND_DATA  = 3'd2,
      KIND_POS   = 3'd3,
      KIND_CLEAR = 3'd4
   } kind_type;

   typedef struct packed {
      logic       emit;     // this step produces a port write
      logic       done;     // this is the item's final step
      logic [7:0] port_value;
      logic [4:0] wait_ms;
      logic       last;
   } step_out_type;

endpackage

// ===== src/lcdnw_step_gen.sv =====
// Combinational step decoder: given the held request and the step index,
// produces the port write for that step. Depends on lcdnw_pkg.
module lcdnw_step_gen #(
   parameter logic [7:0] EN_MASK = 8'(lcdnw_pkg::EN_MASK_DEFAULT),
   parameter logic [7:0] RS_MASK = 8'(lcdnw_pkg::RS_MASK_DEFAULT)
) (
   input  logic [2:0]                  kind,
   input  logic [7:0]                  byte_value,
   input  logic [5:0]                  column,
   input  logic [1:0]                  row,
   input  logic [lcdnw_pkg::STEP_W-1:0] step,
   output lcdnw_pkg::step_out_type      step_out
);
   import lcdnw_pkg::*;

   logic [7:0]        cmd_byte;
   logic [7:0]        rs;
   logic [4:0]        final_wait;
   logic              is_last_byte;
   logic              byte_phase;
   logic [STEP_W-1:0] init_idx;
   logic [1:0]        sub;
   logic [7:0]        hi;
   logic [7:0]        lo;
   logic [7:0]        line_base;

   assign init_idx  = step - STEP_W'(INIT_NIBBLES);
   assign line_base = (row == 2'd2) ? LINE2_BASE : 8'h00;

   always_comb begin
      cmd_byte     = byte_value;
      rs           = 8'h00;
      final_wait   = WAIT_BYTE;
      is_last_byte = 1'b1;
      byte_phase   = 1'b1;
      sub          = step[1:0];
      step_out     = '0;
      case (kind_type'(kind))
         KIND_INIT: begin
            sub = init_idx[1:0];
            byte_phase = (step >= STEP_W'(INIT_NIBBLES));
            is_last_byte = (init_idx[3:2] == 2'd3);
            case (init_idx[3:2])
               2'd0: cmd_byte = CMD_FUNC_SET;
               2'd1: cmd_byte = CMD_DISP_ON;
               2'd2: cmd_byte = CMD_ENTRY;
               default: cmd_byte = CMD_HOME_POS;
            endcase
         end
         KIND_CMD: begin
            cmd_byte = byte_value;
         end
         KIND_DATA: begin
            rs = RS_MASK;
         end
         KIND_POS: begin
            cmd_byte = POS_BASE + line_base + {2'b00, column};
         end
         KIND_CLEAR: begin
            cmd_byte = CMD_CLEAR;
            final_wait = WAIT_CLEAR;
         end
         default: begin
            byte_phase = 1'b0;
         end
      endcase

      hi = cmd_byte & 8'hF0;
      lo = {cmd_byte[3:0], 4'h0};

      if (kind > 3'(KIND_CLEAR)) begin
         // unknown kind: no writes, item retires at once
         step_out.emit = 1'b0;
         step_out.done = 1'b1;
      end else if (!byte_phase) begin
         // power-on nibble sequence of init
         step_out.emit = 1'b1;
         case (step[3:0])
            4'd0: begin step_out.port_value = 8'hFF;           step_out.wait_ms = 5'd20; end
            4'd1: begin step_out.port_value = 8'h30 | EN_MASK; step_out.wait_ms = 5'd0;  end
            4'd2: begin step_out.port_value = 8'h30;           step_out.wait_ms = 5'd10; end
            4'd3: begin step_out.port_value = 8'h30 | EN_MASK; step_out.wait_ms = 5'd0;  end
            4'd4: begin step_out.port_value = 8'h30;           step_out.wait_ms = 5'd1;  end
            4'd5: begin step_out.port_value = 8'h30 | EN_MASK; step_out.wait_ms = 5'd0;  end
            4'd6: begin step_out.port_value = 8'h30;           step_out.wait_ms = 5'd1;  end
            4'd7: begin step_out.port_value = 8'h20 | EN_MASK; step_out.wait_ms = 5'd0;  end
            default: begin step_out.port_value = 8'h20;        step_out.wait_ms = 5'd1;  end
         endcase
      end else begin
         step_out.emit = 1'b1;
         case (sub)
            2'd0: step_out.port_value = hi | EN_MASK | rs;
            2'd1: step_out.port_value = hi | rs;
            2'd2: step_out.port_value = lo | EN_MASK | rs;
            default: begin
               step_out.port_value = lo | rs;
               step_out.wait_ms = final_wait;
               step_out.last = is_last_byte;
               step_out.done = is_last_byte;
            end
         endcase
      end
   end

endmodule

// ===== src/char_lcd_nibble_write_sequencer.sv =====
// Top level of the character LCD 4-bit write sequencer: request register,
// step counter and result register around lcdnw_step_gen. Depends on lcdnw_pkg.
//
// Each request expands into port writes, one per cycle while the result side
// takes them: four for command, data, set position and clear, 25 for init,
// and none for an unknown kind. The step counter walking the held request
// sets that count. The next request is taken in the cycle its
// predecessor's final write enters the result register, so writes of
// consecutive requests follow with no gap. tlast marks a request's final write.
module char_lcd_nibble_write_sequencer #(
   parameter logic [7:0] EN_MASK = 8'(lcdnw_pkg::EN_MASK_DEFAULT),
   parameter logic [7:0] RS_MASK = 8'(lcdnw_pkg::RS_MASK_DEFAULT)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] byte_value, [13:8] column, [15:14] row
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] port_value, [12:8] wait_ms, [15:13] zero
   output logic        rsp_tlast    // last
);
   import lcdnw_pkg::*;

   logic              item_valid_ff, item_valid_in;
   logic [2:0]        kind_ff, kind_in;
   logic [7:0]        byte_ff, byte_in;
   logic [5:0]        column_ff, column_in;
   logic [1:0]        row_ff, row_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        port_ff, port_in;
   logic [4:0]        wait_ff, wait_in;
   logic              last_ff, last_in;

   step_out_type      st;
   logic              out_free;
   logic              step_go;
   logic              req_take;

   lcdnw_step_gen #(
      .EN_MASK (EN_MASK),
      .RS_MASK (RS_MASK)
   ) u_step_gen (
      .kind       (kind_ff),
      .byte_value (byte_ff),
      .column     (column_ff),
      .row        (row_ff),
      .step       (step_ff),
      .step_out   (st)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_go    = item_valid_ff && (out_free || !st.emit);
   assign req_tready = !item_valid_ff || (step_go && st.done);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_valid_in = item_valid_ff;
      kind_in       = kind_ff;
      byte_in       = byte_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      step_in       = step_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
         kind_in       = req_tuser;
         byte_in       = req_tdata[7:0];
         column_in     = req_tdata[13:8];
         row_in        = req_tdata[15:14];
         step_in       = '0;
      end else if (step_go && st.done) begin
         item_valid_in = 1'b0;
      end else if (step_go) begin
         step_in = step_ff + STEP_W'(1);
      end

      out_valid_in = out_valid_ff;
      port_in      = port_ff;
      wait_in      = wait_ff;
      last_in      = last_ff;
      if (step_go && st.emit) begin
         out_valid_in = 1'b1;
         port_in      = st.port_value;
         wait_in      = st.wait_ms;
         last_in      = st.last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         step_ff       <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
         step_ff       <= step_in;
      end
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      column_ff <= column_in;
      row_ff    <= row_in;
      port_ff   <= port_in;
      wait_ff   <= wait_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, wait_ff, port_ff};
   assign rsp_tlast  = last_ff;

   // step counter never runs past the init sequence
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff |-> (step_ff < STEP_W'(INIT_STEPS)))
      else $error("step counter out of range");

   // non-init requests finish within four steps
   a_short_item: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && kind_ff != 3'(KIND_INIT)) |-> (step_ff < STEP_W'(4)))
      else $error("short request ran past four steps");

   // a new transaction is only taken over a held item in its final step
   a_take_over: assert property (@(posedge clock) disable iff (reset)
      (req_take && item_valid_ff) |-> (step_go && st.done))
      else $error("request taken before previous one retired");

   // a write flagged last always retires its request
   a_last_retires: assert property (@(posedge clock) disable iff (reset)
      (step_go && st.emit && st.last) |=> !item_valid_ff || step_ff == '0)
      else $error("request still held after its last write");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the character LCD 4-bit write sequencer.
// Depends on lcdnw_pkg and char_lcd_nibble_write_sequencer.
module tb_top;
   import lcdnw_pkg::*;

   localparam logic [7:0] EN_BIT     = 8'(EN_MASK_DEFAULT);
   localparam logic [7:0] RS_BIT     = 8'(RS_MASK_DEFAULT);
   localparam logic [7:0] PORT_FLOOD = 8'hFF;   // first init write, all lines high
   localparam logic [7:0] NIB_WAKE   = 8'h30;
   localparam logic [7:0] NIB_4BIT   = 8'h20;
   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
   localparam int RANDOM_REQUESTS = 160;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct {
      logic [7:0] port_value;
      logic [4:0] wait_ms;
      logic       last;
   } port_write_type;

   class lcd_write_scoreboard;
      port_write_type pending_writes[$];
      int             mismatches = 0;

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
      endfunction

      function void push_write(logic [7:0] p, logic [4:0] w, logic l);
         port_write_type pw;
         pw.port_value = p;
         pw.wait_ms    = w;
         pw.last       = l;
         pending_writes.push_back(pw);
      endfunction

      // high nibble strobed, then low nibble strobed
      function void push_byte(logic [7:0] b, logic [7:0] rs, logic [4:0] final_wait,
                              logic l);
         logic [7:0] hi;
         logic [7:0] lo;
         hi = b & 8'hF0;
         lo = {b[3:0], 4'h0};
         push_write(hi | EN_BIT | rs, 5'd0, 1'b0);
         push_write(hi | rs, 5'd0, 1'b0);
         push_write(lo | EN_BIT | rs, 5'd0, 1'b0);
         push_write(lo | rs, final_wait, l);
      endfunction

      function void note_request(logic [2:0] kind, logic [7:0] bv, logic [5:0] col,
                                 logic [1:0] row);
         logic [7:0] line_base;
         logic [7:0] pos_cmd;
         case (kind)
            KIND_INIT: begin
               push_write(PORT_FLOOD, 5'd20, 1'b0);
               push_write(NIB_WAKE | EN_BIT, 5'd0, 1'b0);
               push_write(NIB_WAKE, 5'd10, 1'b0);
               push_write(NIB_WAKE | EN_BIT, 5'd0, 1'b0);
               push_write(NIB_WAKE, 5'd1, 1'b0);
               push_write(NIB_WAKE | EN_BIT, 5'd0, 1'b0);
               push_write(NIB_WAKE, 5'd1, 1'b0);
               push_write(NIB_4BIT | EN_BIT, 5'd0, 1'b0);
               push_write(NIB_4BIT, 5'd1, 1'b0);
               push_byte(CMD_FUNC_SET, 8'h00, WAIT_BYTE, 1'b0);
               push_byte(CMD_DISP_ON, 8'h00, WAIT_BYTE, 1'b0);
               push_byte(CMD_ENTRY, 8'h00, WAIT_BYTE, 1'b0);
               push_byte(CMD_HOME_POS, 8'h00, WAIT_BYTE, 1'b1);
            end
            KIND_CMD:   push_byte(bv, 8'h00, WAIT_BYTE, 1'b1);
            KIND_DATA:  push_byte(bv, RS_BIT, WAIT_BYTE, 1'b1);
            KIND_POS: begin
               line_base = (row == 2'd2) ? LINE2_BASE : 8'h00;
               // one-based column, wraps modulo 256
               pos_cmd = CMD_HOME_POS + line_base + {2'b00, col} - 8'd1;
               push_byte(pos_cmd, 8'h00, WAIT_BYTE, 1'b1);
            end
            KIND_CLEAR: push_byte(CMD_CLEAR, 8'h00, WAIT_CLEAR, 1'b1);
            default: ;  // unused kinds produce nothing
         endcase
      endfunction

      function void check_write(logic [7:0] p, logic [4:0] w, logic l);
         port_write_type want;
         if (pending_writes.size() == 0) begin
            flag($sformatf("unexpected write port=%02h wait=%0d last=%0b", p, w, l));
            return;
         end
         want = pending_writes.pop_front();
         if (p !== want.port_value || w !== want.wait_ms || l !== want.last)
            flag($sformatf({"write mismatch: exp port=%02h wait=%0d last=%0b, ",
                            "got port=%02h wait=%0d last=%0b"},
                           want.port_value, want.wait_ms, want.last, p, w, l));
      endfunction

      function void close_out();
         if (pending_writes.size() != 0)
            flag($sformatf("%0d expected writes never arrived", pending_writes.size()));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [7:0] byte_value, [13:8] column, [15:14] row
   logic [2:0]  req_tuser;   // [2:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] port_value, [12:8] wait_ms, [15:13] zero
   logic        rsp_tlast;

   lcd_write_scoreboard sb;
   bit req_burst;
   bit rsp_burst;

   char_lcd_nibble_write_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 9);
   endfunction

   // one request transaction; returns at the falling edge after acceptance
   task automatic send_request(logic [2:0] kind, logic [7:0] bv, logic [5:0] col,
                               logic [1:0] row);
      int gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {row, col, bv};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, bv, col, row);
      @(negedge clock);
   endtask

   task automatic random_request(output bit counted);
      int r;
      logic [2:0] kind;
      logic [5:0] col;
      logic [1:0] row;
      r = $urandom_range(0, 99);
      if (r < 5)       kind = KIND_INIT;
      else if (r < 10) kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      else if (r < 35) kind = KIND_CMD;
      else if (r < 65) kind = KIND_DATA;
      else if (r < 85) kind = KIND_POS;
      else             kind = KIND_CLEAR;
      // mostly legal positions, now and then anything the fields hold
      col = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(1, 40));
      row = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                                        : 2'($urandom_range(1, 2));
      send_request(kind, 8'($urandom_range(0, 255)), col, row);
      counted = (kind <= KIND_CLEAR);
   endtask

   // result side: random stalls, check every accepted write
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap(rsp_burst);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_write(rsp_tdata[7:0], rsp_tdata[12:8], rsp_tlast);
         @(negedge clock);
      end
   end

   initial begin
      int  done_count;
      bit  counted;
      sb = new();
      req_burst  = 1'b0;
      rsp_burst  = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: field extremes, every kind, wrap cases, unused kinds
      send_request(KIND_INIT,  8'h00, 6'd0,  2'd0);
      send_request(KIND_CMD,   8'h00, 6'd0,  2'd0);
      send_request(KIND_CMD,   8'hFF, 6'd63, 2'd3);
      send_request(KIND_CMD,   8'hA5, 6'd1,  2'd1);
      send_request(KIND_DATA,  8'h00, 6'd1,  2'd1);
      send_request(KIND_DATA,  8'hFF, 6'd1,  2'd1);
      send_request(KIND_DATA,  8'h5A, 6'd1,  2'd1);
      send_request(KIND_POS,   8'h00, 6'd1,  2'd1);
      send_request(KIND_POS,   8'h00, 6'd1,  2'd2);
      send_request(KIND_POS,   8'h00, 6'd40, 2'd1);
      send_request(KIND_POS,   8'hFF, 6'd40, 2'd2);
      send_request(KIND_POS,   8'h00, 6'd0,  2'd1);   // column zero wraps below base
      send_request(KIND_POS,   8'h00, 6'd63, 2'd2);   // beyond the line
      send_request(KIND_POS,   8'h00, 6'd5,  2'd0);   // row not 2 -> line one
      send_request(KIND_POS,   8'h00, 6'd5,  2'd3);
      send_request(KIND_CLEAR, 8'hFF, 6'd63, 2'd3);
      send_request(3'd5,       8'h12, 6'd7,  2'd1);
      send_request(3'd6,       8'h34, 6'd7,  2'd2);
      send_request(KIND_UNUSED_HI, 8'hFF, 6'd63, 2'd3);
      send_request(KIND_DATA,  8'h41, 6'd1,  2'd1);
      send_request(KIND_INIT,  8'hFF, 6'd63, 2'd3);

      done_count = 0;
      while (done_count < RANDOM_REQUESTS) begin
         // alternate stretches where one side or the other never idles
         req_burst = (done_count % 40) >= 30;
         rsp_burst = ((done_count + 15) % 50) >= 38;
         random_request(counted);
         if (counted) done_count++;
      end
      req_tvalid <= 1'b0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;

      while (sb.pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.close_out();
      if (sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
